// ===== rtl/core/arpc_pkg.sv =====
// Shared types and constants for the address-resolution cache.
package arpc_pkg;

   localparam int ARPC_TABLE_DEPTH = 16;
   localparam int ARPC_KEY_W       = 32;
   localparam int ARPC_MAC_W       = 48;
   localparam int ARPC_IDX_OUT_W   = 4;
   localparam int ARPC_QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [ARPC_KEY_W-1:0]   ip_addr;
      logic [ARPC_MAC_W-1:0]   mac_addr;
   } item_type;

   // Queue head toward the table engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

// ===== rtl/core/arp_cache_table.sv =====
// Top level of the IPv4-to-MAC address-resolution cache.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    op, ip_addr, mac_addr
//   rsp      out        rsp_valid/stall    hit, mac_out, entry_index
//
// Inserts and lookup misses finish in the compare state of the table engine;
// lookup hits go on to a read state for the registered read of the MAC memory.
// A two-entry request queue keeps taking beats, until it is full, while the
// engine works or a result waits on a stalled rsp channel.
// Synchronous reset clears the valid marks, the replace pointer and the queue.
module arp_cache_table
   import arpc_pkg::*;
#(
   parameter int TABLE_DEPTH = ARPC_TABLE_DEPTH
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [ARPC_KEY_W-1:0]     req_ip_addr,
   input  logic [ARPC_MAC_W-1:0]     req_mac_addr,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic [ARPC_MAC_W-1:0]     rsp_mac_out,
   output logic [ARPC_IDX_OUT_W-1:0] rsp_entry_index
);

   queue_head_type head;
   logic           pop;

   arpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_ip_addr  (req_ip_addr),
      .req_mac_addr (req_mac_addr),
      .head         (head),
      .pop          (pop)
   );

   arpc_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_mac_out     (rsp_mac_out),
      .rsp_entry_index (rsp_entry_index)
   );

endmodule

// ===== rtl/core/arpc_front.sv =====
// Front end: accepts request beats, classifies the operation and queues them.
module arpc_front
   import arpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [ARPC_KEY_W-1:0] req_ip_addr,
   input  logic [ARPC_MAC_W-1:0] req_mac_addr,
   output queue_head_type        head,
   input  logic                  pop
);

   localparam int PTR_W = $clog2(ARPC_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ARPC_QUEUE_DEPTH + 1);

   item_type           slot_ff [ARPC_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               do_pop;
   item_type           new_item;

   assign req_stall = (count_ff == CNT_W'(ARPC_QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      new_item.op       = op_type'(req_op);
      new_item.ip_addr  = req_ip_addr;
      new_item.mac_addr = req_mac_addr;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ARPC_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ARPC_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = slot_ff[rd_ptr_ff];
   end

endmodule

// ===== rtl/core/arpc_back.sv =====
// Back end: key compare, table update, MAC memory and the result register.
module arpc_back
   import arpc_pkg::*;
#(
   parameter int TABLE_DEPTH = ARPC_TABLE_DEPTH
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  queue_head_type            head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic [ARPC_MAC_W-1:0]     rsp_mac_out,
   output logic [ARPC_IDX_OUT_W-1:0] rsp_entry_index
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   item_type                item_ff;
   logic [ARPC_KEY_W-1:0]   key_ff   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [IDX_W-1:0]        slot_ff;
   logic [ARPC_MAC_W-1:0]   mac_mem  [TABLE_DEPTH];
   logic [ARPC_MAC_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;

   logic [TABLE_DEPTH-1:0]  match;
   logic                    found;
   logic [IDX_W-1:0]        match_slot;
   logic [IDX_W-1:0]        target_slot;
   logic [IDX_W+ARPC_IDX_OUT_W-1:0] target_wide;
   logic [IDX_W+ARPC_IDX_OUT_W-1:0] held_wide;

   logic                    out_free;
   logic                    cmp_done;
   logic                    read_done;
   logic                    table_we;
   logic                    key_we;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff,   rsp_hit_in;
   logic [ARPC_MAC_W-1:0]   rsp_mac_ff,   rsp_mac_in;
   logic [ARPC_IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                    load_out;

   // Lowest valid matching entry wins.
   always_comb begin
      found      = 1'b0;
      match_slot = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         match[k] = valid_ff[k] && (key_ff[k] == item_ff.ip_addr);
      end
      for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
         if (match[k]) begin
            found      = 1'b1;
            match_slot = IDX_W'(k);
         end
      end
   end

   assign target_slot = found ? match_slot : ptr_ff;
   assign target_wide = {{ARPC_IDX_OUT_W{1'b0}}, target_slot};
   assign held_wide   = {{ARPC_IDX_OUT_W{1'b0}}, slot_ff};

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A lookup hit goes on to read the MAC memory before it can finish.
   assign cmp_done  = (state_ff == ST_CMP) && out_free
                      && !(item_ff.op == OP_LOOKUP && found);
   assign read_done = (state_ff == ST_READ) && out_free;
   assign table_we  = cmp_done && (item_ff.op == OP_INSERT);
   assign key_we    = table_we && !found;
   assign pop       = head.valid
                      && ((state_ff == ST_IDLE) || cmp_done || read_done);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) state_in = ST_CMP;
         end
         ST_CMP: begin
            if (item_ff.op == OP_LOOKUP && found) begin
               state_in = ST_READ;
            end else if (cmp_done) begin
               state_in = pop ? ST_CMP : ST_IDLE;
            end
         end
         ST_READ: begin
            if (read_done) state_in = pop ? ST_CMP : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (key_we) begin
         valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == IDX_W'(TABLE_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_comb begin
      load_out   = cmp_done || read_done;
      rsp_hit_in = rsp_hit_ff;
      rsp_mac_in = rsp_mac_ff;
      rsp_idx_in = rsp_idx_ff;
      if (read_done) begin
         rsp_hit_in = 1'b1;
         rsp_mac_in = rd_data_ff;
         rsp_idx_in = held_wide[ARPC_IDX_OUT_W-1:0];
      end else if (cmp_done) begin
         if (item_ff.op == OP_INSERT) begin
            rsp_hit_in = found;
            rsp_mac_in = item_ff.mac_addr;
            rsp_idx_in = target_wide[ARPC_IDX_OUT_W-1:0];
         end else begin
            rsp_hit_in = 1'b0;
            rsp_mac_in = '0;
            rsp_idx_in = '0;
         end
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rd_addr = (state_ff == ST_CMP) ? target_slot : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head.item;
      end
      if (state_ff == ST_CMP) begin
         slot_ff <= target_slot;
      end
      if (key_we) begin
         key_ff[ptr_ff] <= item_ff.ip_addr;
      end
      rsp_hit_ff <= rsp_hit_in;
      rsp_mac_ff <= rsp_mac_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   // MAC store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (table_we) begin
         mac_mem[target_slot] <= item_ff.mac_addr;
      end
      rd_data_ff <= mac_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_mac_out     = rsp_mac_ff;
   assign rsp_entry_index = rsp_idx_ff;

endmodule

// ===== verif/arp_cache_table_tb.sv =====
// Self-checking testbench for the arp_cache_table IPv4-to-MAC address cache.
module arp_cache_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import arpc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int POOL_MAX    = 40;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic                      hit;
      logic [ARPC_MAC_W-1:0]     mac;
      logic [ARPC_IDX_OUT_W-1:0] index;
   } arp_answer_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_op;
   logic [ARPC_KEY_W-1:0]     req_ip_addr;
   logic [ARPC_MAC_W-1:0]     req_mac_addr;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_hit;
   logic [ARPC_MAC_W-1:0]     rsp_mac_out;
   logic [ARPC_IDX_OUT_W-1:0] rsp_entry_index;

   // Shadow copy of the cache table.
   logic [ARPC_KEY_W-1:0] cached_key  [ARPC_TABLE_DEPTH] = '{default: '0};
   logic [ARPC_MAC_W-1:0] cached_mac  [ARPC_TABLE_DEPTH] = '{default: '0};
   logic                  cached_live [ARPC_TABLE_DEPTH] = '{default: 1'b0};
   int                    victim_slot = 0;

   arp_answer_type        answer_queue [$];
   logic [ARPC_KEY_W-1:0] key_pool [POOL_MAX];

   int send_idle_pct  = 20;
   int stall_pct      = 20;
   int hold_request   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   arp_cache_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_ip_addr     (req_ip_addr),
      .req_mac_addr    (req_mac_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_mac_out     (rsp_mac_out),
      .rsp_entry_index (rsp_entry_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Apply one beat to the shadow table and return the answer it must produce.
   function automatic arp_answer_type resolve_item(input op_type op,
                                                   input logic [ARPC_KEY_W-1:0] ip,
                                                   input logic [ARPC_MAC_W-1:0] mac);
      arp_answer_type ans;
      int slot;
      slot = -1;
      for (int k = ARPC_TABLE_DEPTH - 1; k >= 0; k--)
         if (cached_live[k] && cached_key[k] == ip) slot = k;
      ans.hit = (slot >= 0);
      if (op == OP_LOOKUP) begin
         if (ans.hit) begin
            ans.mac   = cached_mac[slot];
            ans.index = slot[ARPC_IDX_OUT_W-1:0];
         end else begin
            ans.mac   = '0;
            ans.index = '0;
         end
      end else begin
         if (!ans.hit) begin
            slot = victim_slot;
            cached_key[slot]  = ip;
            cached_live[slot] = 1'b1;
            victim_slot = (slot + 1) % ARPC_TABLE_DEPTH;
         end
         cached_mac[slot] = mac;
         ans.mac   = mac;
         ans.index = slot[ARPC_IDX_OUT_W-1:0];
      end
      return ans;
   endfunction

   function automatic logic [ARPC_KEY_W-1:0] rand_key();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ARPC_MAC_W-1:0] rand_mac();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   // Offer one beat; valid stays high into the next call unless a gap is drawn.
   task automatic send_item(input op_type op, input logic [ARPC_KEY_W-1:0] ip,
                            input logic [ARPC_MAC_W-1:0] mac);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_ip_addr  <= ip;
      req_mac_addr <= mac;
      do @(posedge clock); while (req_stall !== 1'b0);
      answer_queue.push_back(resolve_item(op, ip, mac));
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      arp_answer_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (answer_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result hit=%0b mac=%h index=%0d",
                                      rsp_hit, rsp_mac_out, rsp_entry_index));
         end else begin
            want = answer_queue.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %0b, want %0b", rsp_hit, want.hit));
            if (rsp_mac_out !== want.mac)
               report_mismatch($sformatf("mac_out %h, want %h", rsp_mac_out, want.mac));
            if (rsp_entry_index !== want.index)
               report_mismatch($sformatf("entry_index %0d, want %0d",
                                         rsp_entry_index, want.index));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results outstanding",
                  cycle_count, answer_queue.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Lookups into an empty table miss, including the all-zero key, as reset
   // clears the valid marks but not the key store.
   task automatic test_empty_table();
      send_item(OP_LOOKUP, '0, '0);
      send_item(OP_LOOKUP, '1, '1);
   endtask

   task automatic test_insert_and_update();
      send_item(OP_INSERT, '0, '0);
      send_item(OP_LOOKUP, '0, 48'hDEAD_BEEF_0001);
      send_item(OP_INSERT, '1, '1);
      send_item(OP_LOOKUP, '1, '0);
      // Existing key: overwrite in place, pointer holds.
      send_item(OP_INSERT, '0, 48'h0200_5E00_00FB);
   endtask

   task automatic test_fill_and_evict();
      for (int i = 0; i < ARPC_TABLE_DEPTH - 2; i++)
         send_item(OP_INSERT, 32'hC0A8_0100 + i, rand_mac());
      // Pointer has wrapped: this lands on entry 0 and drops key zero.
      send_item(OP_INSERT, 32'h0A00_0001, 48'h00AA_BBCC_DDEE);
      send_item(OP_LOOKUP, '0, '0);
      send_item(OP_LOOKUP, '1, '0);
   endtask

   task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct,
                                      input int keys);
      op_type                op;
      logic [ARPC_KEY_W-1:0] ip;
      send_idle_pct = snd_pct;
      stall_pct     = rcv_pct;
      for (int i = 0; i < keys; i++) key_pool[i] = rand_key();
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
         ip = ($urandom_range(99) < 85) ? key_pool[$urandom_range(keys - 1)] : rand_key();
         send_item(op, ip, rand_mac());
      end
   endtask

   // Hold the result channel while the sender keeps offering beats.
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 150;
      for (int n = 0; n < 16; n++)
         send_item(($urandom_range(1) == 1) ? OP_INSERT : OP_LOOKUP,
                   key_pool[$urandom_range(11)], rand_mac());
   endtask

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_op       <= OP_LOOKUP;
      req_ip_addr  <= '0;
      req_mac_addr <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_insert_and_update();
      test_fill_and_evict();
      test_random_traffic(460, 37, 82, 24);
      test_random_traffic(460, 82, 37, 12);
      test_result_backpressure();
      test_random_traffic(460, 0, 0, 40);

      req_valid <= 1'b0;
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
